// File: sv/ddpm_pkg.sv
// ----------------------------------------------------------------------------
// ddpm_pkg
// Shared widths, register codes and pipeline types of the drive pulse mixer.
// ----------------------------------------------------------------------------
package ddpm_pkg;

    // speed format: Q2.FRAC_BITS, (1 << FRAC_BITS) is 1.0
    localparam int FRAC_BITS = 14;
    localparam int SPEED_W   = 16;
    localparam int SUM_W     = SPEED_W + 1;            // mixed speed, signed
    localparam int MAG_W     = SUM_W;                  // magnitude of a mixed speed
    localparam int REM_W     = MAG_W + 1;              // divider partial remainder
    localparam int QUO_W     = FRAC_BITS + 1;          // scaled magnitude, up to 1.0
    localparam int CLP_W     = FRAC_BITS + 2;          // clamped speed, signed
    localparam int WIDE_W    = SUM_W + FRAC_BITS + 2;  // compare width

    localparam int NEUT_W    = 12;
    localparam int SPAN_W    = 10;
    localparam int DB_W      = 15;
    localparam int PULSE_W   = 12;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 2;

    localparam int PROD_W    = CLP_W + SPAN_W + 1;
    localparam int OFF_W     = PROD_W - FRAC_BITS;
    localparam int PSUM_W    = ((OFF_W > NEUT_W + 1) ? OFF_W : NEUT_W + 1) + 1;

    localparam logic signed [WIDE_W-1:0] ONE_WIDE = WIDE_W'(1) <<< FRAC_BITS;
    localparam logic signed [CLP_W-1:0]  ONE_CLP  = CLP_W'(1) <<< FRAC_BITS;
    localparam logic signed [PROD_W-1:0] TRUNC_BIAS = (PROD_W'(1) <<< FRAC_BITS) - PROD_W'(1);
    localparam logic signed [PSUM_W-1:0] PULSE_MAX  = PSUM_W'((1 << PULSE_W) - 1);

    localparam logic [NEUT_W-1:0] NEUTRAL_RST  = NEUT_W'(1500);
    localparam logic [SPAN_W-1:0] SPAN_RST     = SPAN_W'(500);
    localparam logic [DB_W-1:0]   DEADBAND_RST = DB_W'(819);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEUTRAL  = 2'd0,
        REG_SPAN     = 2'd1,
        REG_DEADBAND = 2'd2
    } cfg_reg_t;

    // data that rides along the divider stages
    typedef struct packed {
        logic                    mix;
        logic                    scale;
        logic                    neg_l;
        logic                    neg_r;
        logic signed [SUM_W-1:0] raw_l;
        logic signed [SUM_W-1:0] raw_r;
    } div_side_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag_l;
        logic [MAG_W-1:0] mag_r;
        logic [MAG_W-1:0] den;
        div_side_t        side;
    } div_in_t;

    typedef struct packed {
        logic [QUO_W-1:0] quo_l;
        logic [QUO_W-1:0] quo_r;
        div_side_t        side;
    } div_out_t;

endpackage

// File: sv/differential_drive_pulse_mixer_core.sv
// ----------------------------------------------------------------------------
// differential_drive_pulse_mixer_core
// Mixes linear/angular or direct left/right speeds and turns them into
// servo pulse widths in microseconds.
// ----------------------------------------------------------------------------
// pipeline from input accept to m_tvalid: 2 mix stages,
//   FRAC_BITS + 1 divider stages, 4 clamp/multiply/pulse stages
// throughput: one item per cycle while m_tready does not stall the output; the divider takes one quotient bit per stage
// a stall on m_tready holds the whole pipeline
// reset clears all valid bits and loads the register defaults 1500/500/819
module differential_drive_pulse_mixer_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ddpm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ddpm_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [2*ddpm_pkg::SPEED_W-1:0]   s_tdata,   // first_speed, second_speed
    input  logic                             s_tuser,   // req_type
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [2*ddpm_pkg::PULSE_W-1:0]   m_tdata    // left_pulse_us, right_pulse_us
);
    import ddpm_pkg::*;

    logic [NEUT_W-1:0] neutral_reg;
    logic [SPAN_W-1:0] span_reg;
    logic [DB_W-1:0]   deadband_reg;

    logic                     adv;
    logic                     s1_vld_reg;
    logic                     s1_mix_reg;
    logic signed [SUM_W-1:0]  s1_l_reg;
    logic signed [SUM_W-1:0]  s1_r_reg;
    logic signed [SUM_W-1:0]  s1_l_next;
    logic signed [SUM_W-1:0]  s1_r_next;
    logic signed [SUM_W-1:0]  spd_a;
    logic signed [SUM_W-1:0]  spd_b;
    logic                     s2_vld_reg;
    div_in_t                  s2_reg;
    div_in_t                  s2_next;
    logic [MAG_W-1:0]         mx;
    logic                     div_vld;
    div_out_t                 div_out;
    logic                     s3_vld_reg;
    logic signed [CLP_W-1:0]  s3_spd_l_reg;
    logic signed [CLP_W-1:0]  s3_spd_r_reg;
    logic                     s4_vld_reg;
    logic signed [PROD_W-1:0] s4_prod_l_reg;
    logic signed [PROD_W-1:0] s4_prod_r_reg;
    logic                     s5_vld_reg;
    logic signed [OFF_W-1:0]  s5_off_l_reg;
    logic signed [OFF_W-1:0]  s5_off_r_reg;
    logic                     out_vld_reg;
    logic [PULSE_W-1:0]       left_reg;
    logic [PULSE_W-1:0]       right_reg;
    logic signed [WIDE_W-1:0] chk_raw_l;
    logic signed [WIDE_W-1:0] chk_raw_r;

    // select scaled or clamped raw speed, then zero it inside the deadband
    function automatic logic signed [CLP_W-1:0] pick_speed(
        input logic                    scale,
        input logic                    neg,
        input logic [QUO_W-1:0]        quo,
        input logic signed [SUM_W-1:0] raw,
        input logic [DB_W-1:0]         db
    );
        logic signed [CLP_W-1:0]  qs;
        logic signed [WIDE_W-1:0] rw;
        logic signed [CLP_W-1:0]  spd;
        logic [CLP_W-1:0]         mg;
        qs = signed'({1'b0, quo});
        rw = WIDE_W'(raw);
        if (scale) begin
            spd = neg ? -qs : qs;
        end else if (rw > ONE_WIDE) begin
            spd = ONE_CLP;
        end else if (rw < -ONE_WIDE) begin
            spd = -ONE_CLP;
        end else begin
            spd = CLP_W'(rw);
        end
        mg = spd[CLP_W-1] ? CLP_W'(-spd) : CLP_W'(spd);
        if (WIDE_W'(mg) < WIDE_W'(db)) begin
            spd = '0;
        end
        return spd;
    endfunction

    // truncate toward zero on the divide by 1.0
    function automatic logic signed [OFF_W-1:0] to_offset(
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [PROD_W-1:0] biased;
        biased = prod + (prod[PROD_W-1] ? TRUNC_BIAS : PROD_W'(0));
        return OFF_W'(biased >>> FRAC_BITS);
    endfunction

    function automatic logic [PULSE_W-1:0] to_pulse(
        input logic [NEUT_W-1:0]       neutral,
        input logic signed [OFF_W-1:0] off
    );
        logic signed [PSUM_W-1:0] sum;
        logic [PULSE_W-1:0]       p;
        sum = PSUM_W'(signed'({1'b0, neutral})) + PSUM_W'(off);
        if (sum < 0) begin
            p = '0;
        end else if (sum > PULSE_MAX) begin
            p = '1;
        end else begin
            p = PULSE_W'(sum);
        end
        return p;
    endfunction

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neutral_reg  <= NEUTRAL_RST;
            span_reg     <= SPAN_RST;
            deadband_reg <= DEADBAND_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_NEUTRAL:  neutral_reg  <= cfg_wdata[NEUT_W-1:0];
                REG_SPAN:     span_reg     <= cfg_wdata[SPAN_W-1:0];
                REG_DEADBAND: deadband_reg <= cfg_wdata[DB_W-1:0];
                default: ;
            endcase
        end
    end

    // the output register frees whenever it is empty or being taken
    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;

    // stage 1: mix
    always_comb begin
        spd_a = SUM_W'(signed'(s_tdata[SPEED_W-1:0]));
        spd_b = SUM_W'(signed'(s_tdata[2*SPEED_W-1:SPEED_W]));
        s1_l_next = s_tuser ? spd_a - spd_b : spd_a;
        s1_r_next = s_tuser ? spd_a + spd_b : spd_b;
    end

    // stage 2: magnitudes, larger one, scale decision
    always_comb begin
        s2_next.side.mix   = s1_mix_reg;
        s2_next.side.neg_l = s1_l_reg[SUM_W-1];
        s2_next.side.neg_r = s1_r_reg[SUM_W-1];
        s2_next.side.raw_l = s1_l_reg;
        s2_next.side.raw_r = s1_r_reg;
        s2_next.mag_l = s1_l_reg[SUM_W-1] ? MAG_W'(-s1_l_reg) : MAG_W'(s1_l_reg);
        s2_next.mag_r = s1_r_reg[SUM_W-1] ? MAG_W'(-s1_r_reg) : MAG_W'(s1_r_reg);
        mx = (s2_next.mag_l > s2_next.mag_r) ? s2_next.mag_l : s2_next.mag_r;
        s2_next.den = mx;
        s2_next.side.scale = s1_mix_reg && (signed'(WIDE_W'(mx)) > ONE_WIDE);
    end

    ddpm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_vld   (s2_vld_reg),
        .in_data  (s2_reg),
        .out_vld  (div_vld),
        .out_data (div_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            s1_vld_reg  <= s_tvalid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= div_vld;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            out_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_mix_reg    <= s_tuser;
            s1_l_reg      <= s1_l_next;
            s1_r_reg      <= s1_r_next;
            s2_reg        <= s2_next;
            s3_spd_l_reg  <= pick_speed(div_out.side.scale, div_out.side.neg_l,
                                        div_out.quo_l, div_out.side.raw_l, deadband_reg);
            s3_spd_r_reg  <= pick_speed(div_out.side.scale, div_out.side.neg_r,
                                        div_out.quo_r, div_out.side.raw_r, deadband_reg);
            s4_prod_l_reg <= PROD_W'(s3_spd_l_reg) * PROD_W'(signed'({1'b0, span_reg}));
            s4_prod_r_reg <= PROD_W'(s3_spd_r_reg) * PROD_W'(signed'({1'b0, span_reg}));
            s5_off_l_reg  <= to_offset(s4_prod_l_reg);
            s5_off_r_reg  <= to_offset(s4_prod_r_reg);
            left_reg      <= to_pulse(neutral_reg, s5_off_l_reg);
            right_reg     <= to_pulse(neutral_reg, s5_off_r_reg);
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {right_reg, left_reg};

    assign chk_raw_l = WIDE_W'(div_out.side.raw_l);
    assign chk_raw_r = WIDE_W'(div_out.side.raw_r);

    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_speed_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_vld_reg |-> (s3_spd_l_reg <= ONE_CLP) && (s3_spd_l_reg >= -ONE_CLP)
                    && (s3_spd_r_reg <= ONE_CLP) && (s3_spd_r_reg >= -ONE_CLP))
        else $error("speed after scaling and clamping exceeds full scale");

    a_unscaled_mix_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        div_vld && div_out.side.mix && !div_out.side.scale
            |-> (chk_raw_l <= ONE_WIDE) && (chk_raw_l >= -ONE_WIDE)
             && (chk_raw_r <= ONE_WIDE) && (chk_raw_r >= -ONE_WIDE))
        else $error("mixed item skipped scaling although a speed exceeds full scale");

endmodule

// File: sv/ddpm_div.sv
// ----------------------------------------------------------------------------
// ddpm_div
// Pipelined restoring divider, two lanes over one divisor: computes
// floor((mag << FRAC_BITS) / den), one quotient bit per stage.
// ----------------------------------------------------------------------------
module ddpm_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_vld,
    input  ddpm_pkg::div_in_t  in_data,
    output logic               out_vld,
    output ddpm_pkg::div_out_t out_data
);
    import ddpm_pkg::*;

    logic [QUO_W-1:0] vld_reg;
    logic [REM_W-1:0] rem_l_reg [QUO_W];
    logic [REM_W-1:0] rem_r_reg [QUO_W];
    logic [QUO_W-1:0] quo_l_reg [QUO_W];
    logic [QUO_W-1:0] quo_r_reg [QUO_W];
    logic [MAG_W-1:0] den_reg   [QUO_W];
    div_side_t        side_reg  [QUO_W];

    genvar k;
    for (k = 0; k < QUO_W; k++) begin : g_stage
        logic [REM_W-1:0] src_l;
        logic [REM_W-1:0] src_r;
        logic [REM_W-1:0] dif_l;
        logic [REM_W-1:0] dif_r;
        logic             bit_l;
        logic             bit_r;
        logic [QUO_W-1:0] qprev_l;
        logic [QUO_W-1:0] qprev_r;
        logic [MAG_W-1:0] den_in;
        div_side_t        side_in;
        logic             vld_in;
        logic [REM_W-1:0] rem_l_next;
        logic [REM_W-1:0] rem_r_next;
        logic [QUO_W-1:0] quo_l_next;
        logic [QUO_W-1:0] quo_r_next;

        if (k == 0) begin : g_first
            // the top bits of mag << FRAC_BITS stand below den, so the first
            // partial remainder is mag itself
            assign src_l   = REM_W'(in_data.mag_l);
            assign src_r   = REM_W'(in_data.mag_r);
            assign qprev_l = '0;
            assign qprev_r = '0;
            assign den_in  = in_data.den;
            assign side_in = in_data.side;
            assign vld_in  = in_vld;
        end else begin : g_next
            assign src_l   = {rem_l_reg[k-1][REM_W-2:0], 1'b0};
            assign src_r   = {rem_r_reg[k-1][REM_W-2:0], 1'b0};
            assign qprev_l = quo_l_reg[k-1];
            assign qprev_r = quo_r_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        always_comb begin
            dif_l      = src_l - REM_W'(den_in);
            dif_r      = src_r - REM_W'(den_in);
            bit_l      = (src_l >= REM_W'(den_in));
            bit_r      = (src_r >= REM_W'(den_in));
            rem_l_next = bit_l ? dif_l : src_l;
            rem_r_next = bit_r ? dif_r : src_r;
            quo_l_next = {qprev_l[QUO_W-2:0], bit_l};
            quo_r_next = {qprev_r[QUO_W-2:0], bit_r};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_l_reg[k] <= rem_l_next;
                rem_r_reg[k] <= rem_r_next;
                quo_l_reg[k] <= quo_l_next;
                quo_r_reg[k] <= quo_r_next;
                den_reg[k]   <= den_in;
                side_reg[k]  <= side_in;
            end
        end
    end

    assign out_vld        = vld_reg[QUO_W-1];
    assign out_data.quo_l = quo_l_reg[QUO_W-1];
    assign out_data.quo_r = quo_r_reg[QUO_W-1];
    assign out_data.side  = side_reg[QUO_W-1];

endmodule
